FILE: rtl/hcbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types, constants and helpers for the HTTP chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int unsigned SIZE_BITS  = 32;
  localparam int unsigned QUEUE_AW   = 1;
  localparam int unsigned QUEUE_DEPTH = 2 ** QUEUE_AW;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [1:0] ST_ZERO_CHUNK = 2'd0;
  localparam logic [1:0] ST_CLEAN      = 2'd1;
  localparam logic [1:0] ST_NO_HEADER  = 2'd2;
  localparam logic [1:0] ST_TRUNCATED  = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_cr;
    logic       is_lf;
    logic       is_hex;
    logic [3:0] hex_val;
  } token_t;

  typedef struct packed {
    logic       full;
    logic       empty;
  } queue_status_t;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

FILE: rtl/hcbd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_front
// Input side: accept raw request bytes and classify them into queue tokens.
// ----------------------------------------------------------------------------
module hcbd_front import hcbd_pkg::*; (
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [7:0] data_byte
  input  logic          s_axis_tlast,   // end_of_request
  input  queue_status_t q_status_i,
  output logic          push_o,
  output token_t        push_tok_o
);

  logic [4:0] hex;

  assign hex           = hex_decode(s_axis_tdata);
  assign s_axis_tready = !q_status_i.full;
  assign push_o        = s_axis_tvalid && !q_status_i.full;

  always_comb begin
    push_tok_o.data    = s_axis_tdata;
    push_tok_o.last    = s_axis_tlast;
    push_tok_o.is_cr   = (s_axis_tdata == CH_CR);
    push_tok_o.is_lf   = (s_axis_tdata == CH_LF);
    push_tok_o.is_hex  = hex[4];
    push_tok_o.hex_val = hex[3:0];
  end

endmodule

FILE: rtl/hcbd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_queue
// Short token queue between the classifier and the chunk parser.
// ----------------------------------------------------------------------------
module hcbd_queue import hcbd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  token_t        push_tok_i,
  input  logic          pop_i,
  output token_t        head_o,
  output queue_status_t status_o
);

  token_t              mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]   count_q, count_d;

  assign status_o.full  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

endmodule

FILE: rtl/hcbd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_back
// Parser: header match, chunk size lines, chunk data, skip of the two bytes after each chunk's data, status.
// ----------------------------------------------------------------------------
module hcbd_back import hcbd_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  token_t        head_i,
  input  queue_status_t q_status_i,
  output logic          pop_o,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [7:0]    m_axis_tdata,   // [7:0] out_byte
  output logic          m_axis_tlast,   // done_res
  output logic [4:0]    m_axis_tuser    // [0] has_byte, [1] in_body,
                                        // [2] chunk_first, [4:3] end_status
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_SIZE,
    PH_DATA,
    PH_SKIP,
    PH_DONE
  } phase_e;

  phase_e               phase_q, phase_d;
  logic [1:0]           hdr_cnt_q, hdr_cnt_d;
  logic [SIZE_BITS-1:0] accum_q, accum_d;
  logic                 closed_q, closed_d;
  logic                 prev_cr_q, prev_cr_d;
  logic [SIZE_BITS-1:0] remain_q, remain_d;
  logic [1:0]           skip_q, skip_d;
  logic                 first_q, first_d;

  logic                 out_valid_q;
  logic [7:0]           out_byte_q;
  logic                 out_last_q;
  logic [4:0]           out_user_q;

  logic                 has, body, first, emit;
  logic [1:0]           status;
  logic [SIZE_BITS-1:0] remain_dec;

  assign pop_o      = !q_status_i.empty && (!out_valid_q || m_axis_tready);
  assign remain_dec = remain_q - 1'b1;

  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    accum_d   = accum_q;
    closed_d  = closed_q;
    prev_cr_d = prev_cr_q;
    remain_d  = remain_q;
    skip_d    = skip_q;
    first_d   = first_q;
    has       = 1'b0;
    body      = 1'b0;
    first     = 1'b0;
    status    = ST_ZERO_CHUNK;

    unique case (phase_q)
      PH_HEADER: begin
        has = 1'b1;
        if (head_i.is_cr) begin
          hdr_cnt_d = (hdr_cnt_q == 2'd2) ? 2'd3 : 2'd1;
        end else if (head_i.is_lf) begin
          if (hdr_cnt_q == 2'd3) begin
            hdr_cnt_d = 2'd0;
            phase_d   = PH_SIZE;
            accum_d   = '0;
            closed_d  = 1'b0;
            prev_cr_d = 1'b0;
          end else begin
            hdr_cnt_d = (hdr_cnt_q == 2'd1) ? 2'd2 : 2'd0;
          end
        end else begin
          hdr_cnt_d = 2'd0;
        end
      end
      PH_SIZE: begin
        if (head_i.is_lf && prev_cr_q) begin
          if (accum_q == '0) begin
            phase_d = PH_DONE;
          end else begin
            remain_d = accum_q;
            first_d  = 1'b1;
            phase_d  = PH_DATA;
          end
          prev_cr_d = 1'b0;
        end else begin
          if (!closed_q) begin
            if (!head_i.is_hex) begin
              closed_d = 1'b1;
            end else if (accum_q[SIZE_BITS-1 -: 4] != 4'd0) begin
              accum_d = '1;
            end else begin
              accum_d = {accum_q[SIZE_BITS-5:0], head_i.hex_val};
            end
          end
          prev_cr_d = head_i.is_cr;
        end
      end
      PH_DATA: begin
        has      = 1'b1;
        body     = 1'b1;
        first    = first_q;
        first_d  = 1'b0;
        remain_d = remain_dec;
        if (remain_dec == '0) begin
          phase_d = PH_SKIP;
          skip_d  = 2'd2;
        end
      end
      PH_SKIP: begin
        if (skip_q != 2'd0) begin
          skip_d = skip_q - 1'b1;
        end
        if (skip_q <= 2'd1) begin
          phase_d   = PH_SIZE;
          accum_d   = '0;
          closed_d  = 1'b0;
          prev_cr_d = 1'b0;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase

    if (head_i.last) begin
      if (phase_d == PH_HEADER) begin
        status = ST_NO_HEADER;
      end else if (phase_d == PH_DONE) begin
        status = ST_ZERO_CHUNK;
      end else if (phase_d == PH_DATA) begin
        status = ST_TRUNCATED;
      end else begin
        status = ST_CLEAN;
      end
      phase_d   = PH_HEADER;
      hdr_cnt_d = 2'd0;
      accum_d   = '0;
      closed_d  = 1'b0;
      prev_cr_d = 1'b0;
      remain_d  = '0;
      skip_d    = 2'd0;
      first_d   = 1'b0;
    end

    emit = has || head_i.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_cnt_q   <= 2'd0;
      accum_q     <= '0;
      closed_q    <= 1'b0;
      prev_cr_q   <= 1'b0;
      remain_q    <= '0;
      skip_q      <= 2'd0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= 8'd0;
      out_last_q  <= 1'b0;
      out_user_q  <= 5'd0;
    end else begin
      if (pop_o) begin
        phase_q     <= phase_d;
        hdr_cnt_q   <= hdr_cnt_d;
        accum_q     <= accum_d;
        closed_q    <= closed_d;
        prev_cr_q   <= prev_cr_d;
        remain_q    <= remain_d;
        skip_q      <= skip_d;
        first_q     <= first_d;
        out_valid_q <= emit;
        if (emit) begin
          out_byte_q <= has ? head_i.data : 8'd0;
          out_last_q <= head_i.last;
          out_user_q <= {status, first, body, has};
        end
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

endmodule

FILE: rtl/http_chunked_body_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_core
// Streams an HTTP request byte by byte and removes chunked transfer framing.
//
// Input stream: one request byte per transaction; tlast marks the final byte.
// Output stream: one transaction per passed header or chunk data byte, plus
// one for the final input byte, which carries tlast and the end status in
// tuser (0 zero chunk seen, 1 ended cleanly, 2 no header end so discard the
// whole request, 3 last chunk truncated so discard it).
// Throughput: one byte per cycle sustained while m_axis_tready stays high. Each
// input transaction reaches its matching output through the two-entry token
// queue and then through the parser's output register.
// The parser takes a token only while the output register is empty or being
// read, so a stalled receiver holds the output register and every byte behind
// it; the queue fills and tready drops once both entries are taken. Bytes that
// yield no output pass through the parser at one per cycle under that condition.
// Reset clears the queue, the output register and the parser to the header
// state; after each final byte the parser also returns to the header state.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_core import hcbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tlast,   // end_of_request
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast,   // done_res
  output logic [4:0] m_axis_tuser    // [0] has_byte, [1] in_body,
                                     // [2] chunk_first, [4:3] end_status
);

  queue_status_t q_status;
  logic          push, pop;
  token_t        push_tok, head_tok;

  hcbd_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_status_i    (q_status),
    .push_o        (push),
    .push_tok_o    (push_tok)
  );

  hcbd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_tok_i (push_tok),
    .pop_i      (pop),
    .head_o     (head_tok),
    .status_o   (q_status)
  );

  hcbd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_tok),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
